[rtl/mctach_pkg.sv]
// Shared types and constants for the multichannel capture tachometer.
// Used by the controller, the datapath, the divider and the top level. No dependencies.
package mctach_pkg;

    localparam int unsigned CAP_W   = 16;   // timer capture width
    localparam int unsigned SPEED_W = 24;   // numerator and speed width
    localparam int unsigned TICKS_W = 8;    // idle counter and timeout width
    localparam int unsigned CH_W    = 4;    // channel field width
    localparam int unsigned CFG_IW  = 1;    // configuration index width
    localparam int unsigned MAX_REPORT = 16;

    localparam logic [CFG_IW-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_NUMER   = 1'b1;

    localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 8'd20;
    localparam logic [SPEED_W-1:0] NUMER_RESET   = 24'd120000;
    localparam logic [TICKS_W-1:0] TICKS_MAX     = 8'hFF;
    localparam logic [CAP_W:0]     PERIOD_WRAP   = 17'h0FFFF;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_DIV    = 5'b00100,
        S_STORE  = 5'b01000,
        S_TICK   = 5'b10000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // latch the accepted transaction
        logic div_start;   // compute the period and start the divider
        logic cap_write;   // store the capture and emit its result
        logic tick_step;   // update one channel of the tick sweep and emit it
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic chan_ok;
        logic div_done;
        logic idx_last;
    } t_status;

endpackage

[rtl/multichannel_capture_tachometer_unit.sv]
// Top level of the multichannel capture tachometer: configuration registers and assertions.
// Depends on mctach_pkg, mctach_ctrl and mctach_dp.

// A transaction is accepted when i_start is high while o_busy is low. A capture
// transaction (i_req_type low) computes the period since the channel's previous
// capture and divides speed_numerator by it with a one-bit-per-cycle divider (a zero
// period gives the numerator itself); its single result follows the decode state, the
// 24 divider steps, completion and store. A capture to a channel at or above CHANNELS
// produces no result and frees the block straight from its decode state. A tick
// transaction sweeps the stored channels one per cycle, so it produces min(CHANNELS, 16)
// results on consecutive cycles, the final one marked by o_last. Each result is presented for
// exactly one cycle with o_valid high; the receiver must take it then, as there is
// no backpressure. The configuration registers may be written only while the block
// is idle. Channels at or above 16 can never receive a capture, so their speed is
// always zero and is neither stored nor reported.
module multichannel_capture_tachometer_unit #(
    parameter int unsigned CHANNELS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_req_type,
    input  logic [mctach_pkg::CH_W-1:0]    i_channel,
    input  logic [mctach_pkg::CAP_W-1:0]   i_capture_value,
    input  logic                           i_cfg_we,
    input  logic [mctach_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [mctach_pkg::SPEED_W-1:0] i_cfg_data,
    output logic                           o_valid,
    output logic [mctach_pkg::CH_W-1:0]    o_out_channel,
    output logic [mctach_pkg::SPEED_W-1:0] o_speed_rpm,
    output logic                           o_stopped_now,
    output logic                           o_last
);
    import mctach_pkg::*;

    logic [TICKS_W-1:0] r_timeout;
    logic [SPEED_W-1:0] r_numer;
    t_cmd               cmd;
    t_status            status;

    // Configuration registers. The timeout takes the low byte of the write data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_numer   <= NUMER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT: r_timeout <= i_cfg_data[TICKS_W-1:0];
                CFG_NUMER:   r_numer   <= i_cfg_data;
                default:     r_numer   <= r_numer;
            endcase
        end
    end

    mctach_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mctach_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_req_type      (i_req_type),
        .i_channel       (i_channel),
        .i_capture_value (i_capture_value),
        .i_timeout       (r_timeout),
        .i_numer         (r_numer),
        .o_valid         (o_valid),
        .o_out_channel   (o_out_channel),
        .o_speed_rpm     (o_speed_rpm),
        .o_stopped_now   (o_stopped_now),
        .o_last          (o_last)
    );

    // An accepted transaction always raises busy in the cycle after acceptance.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");

    // A tick sweep emits its results on consecutive cycles up to the final one.
    a_sweep_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("result sequence broken before its final result");

    // A channel stopped by timeout reports zero speed.
    a_stopped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stopped_now) |-> (o_speed_rpm == '0))
        else $error("stopped channel reported a nonzero speed");

    // A new transaction cannot be accepted while results of the previous one are pending.
    a_no_accept_mid_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_busy)
        else $error("block idle in the middle of a result sequence");

endmodule

[rtl/mctach_div.sv]
// Restoring divider for the tachometer: 24-bit dividend by 16-bit divisor, one bit per cycle.
// Depends on mctach_pkg.
module mctach_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mctach_pkg::SPEED_W-1:0] i_dividend,
    input  logic [mctach_pkg::CAP_W-1:0]   i_divisor,
    output logic [mctach_pkg::SPEED_W-1:0] o_quot,
    output logic                          o_done
);
    import mctach_pkg::*;

    localparam int unsigned CNT_W = $clog2(SPEED_W + 1);

    logic [CAP_W-1:0]   r_rem,  n_rem;
    logic [SPEED_W-1:0] r_quot, n_quot;
    logic [CAP_W-1:0]   r_dvs,  n_dvs;
    logic [CNT_W-1:0]   r_cnt,  n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CAP_W:0]     shifted;
    logic [CAP_W:0]     diff;

    always_comb begin
        shifted = {r_rem, r_quot[SPEED_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        n_rem   = r_rem;
        n_quot  = r_quot;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quot = i_dividend;
            n_dvs  = i_divisor;
            n_cnt  = CNT_W'(SPEED_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_dvs}) begin
                n_rem  = diff[CAP_W-1:0];
                n_quot = {r_quot[SPEED_W-2:0], 1'b1};
            end else begin
                n_rem  = shifted[CAP_W-1:0];
                n_quot = {r_quot[SPEED_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_dvs  <= n_dvs;
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

[rtl/mctach_dp.sv]
// Datapath of the tachometer: per-channel stores, period logic, divider and result registers.
// Depends on mctach_pkg and mctach_div.
module mctach_dp #(
    parameter int unsigned CHANNELS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mctach_pkg::t_cmd               i_cmd,
    output mctach_pkg::t_status            o_status,
    input  logic                           i_req_type,
    input  logic [mctach_pkg::CH_W-1:0]    i_channel,
    input  logic [mctach_pkg::CAP_W-1:0]   i_capture_value,
    input  logic [mctach_pkg::TICKS_W-1:0] i_timeout,
    input  logic [mctach_pkg::SPEED_W-1:0] i_numer,
    output logic                           o_valid,
    output logic [mctach_pkg::CH_W-1:0]    o_out_channel,
    output logic [mctach_pkg::SPEED_W-1:0] o_speed_rpm,
    output logic                           o_stopped_now,
    output logic                           o_last
);
    import mctach_pkg::*;

    // Only channels that a capture can address or a tick can report are stored.
    localparam int unsigned ST = (CHANNELS < MAX_REPORT) ? CHANNELS : MAX_REPORT;
    localparam int unsigned IW = (ST > 1) ? $clog2(ST) : 1;
    localparam int unsigned CMP_W = CH_W + 3;

    logic [CAP_W-1:0]   r_prev  [ST];
    logic [SPEED_W-1:0] r_speed [ST];
    logic [TICKS_W-1:0] r_idle  [ST];

    logic               r_is_tick;
    logic [CH_W-1:0]    r_ch;
    logic [CAP_W-1:0]   r_cur;
    logic [IW-1:0]      r_idx;
    logic               r_zero;

    logic               r_valid;
    logic [CH_W-1:0]    r_o_ch;
    logic [SPEED_W-1:0] r_o_speed;
    logic               r_o_stopped;
    logic               r_o_last;

    logic [CAP_W-1:0]   prev_sel;
    logic [CAP_W:0]     wrap_sum;
    logic [CAP_W-1:0]   period;
    logic [SPEED_W-1:0] quot;
    logic               div_done;
    logic [SPEED_W-1:0] cap_speed;
    logic [TICKS_W-1:0] cnt_inc;
    logic               hit;
    logic [SPEED_W-1:0] tick_speed;

    mctach_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (i_numer),
        .i_divisor  (period),
        .o_quot     (quot),
        .o_done     (div_done)
    );

    always_comb begin
        prev_sel = r_prev[r_idx];
        wrap_sum = {1'b0, r_cur} + PERIOD_WRAP - {1'b0, prev_sel};
        if (r_cur > prev_sel) begin
            period = r_cur - prev_sel;
        end else begin
            period = wrap_sum[CAP_W-1:0];
        end
        cap_speed = r_zero ? i_numer : quot;

        // Idle counter update of the channel under the sweep index.
        cnt_inc    = (r_idle[r_idx] == TICKS_MAX) ? TICKS_MAX : r_idle[r_idx] + 1'b1;
        hit        = (cnt_inc >= i_timeout);
        tick_speed = hit ? '0 : r_speed[r_idx];
    end

    assign o_status.is_tick  = r_is_tick;
    assign o_status.chan_ok  = ({3'b000, r_ch} < CMP_W'(CHANNELS));
    assign o_status.div_done = div_done;
    assign o_status.idx_last = (r_idx == IW'(ST - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_tick <= i_req_type;
            r_ch      <= i_channel;
            r_cur     <= i_capture_value;
        end
        if (i_cmd.div_start) begin
            r_zero <= (period == '0);
        end
        if (i_cmd.cap_write || i_cmd.tick_step) begin
            r_o_ch      <= i_cmd.tick_step ? CH_W'(r_idx) : r_ch;
            r_o_speed   <= i_cmd.tick_step ? tick_speed : cap_speed;
            r_o_stopped <= i_cmd.tick_step && hit;
            r_o_last    <= i_cmd.cap_write || (r_idx == IW'(ST - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            for (int i = 0; i < ST; i++) begin
                r_prev[i]  <= '0;
                r_speed[i] <= '0;
                r_idle[i]  <= '0;
            end
        end else begin
            r_valid <= i_cmd.cap_write || i_cmd.tick_step;
            if (i_cmd.load) begin
                r_idx <= i_req_type ? '0 : i_channel[IW-1:0];
            end else if (i_cmd.tick_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.cap_write) begin
                r_prev[r_idx]  <= r_cur;
                r_speed[r_idx] <= cap_speed;
                r_idle[r_idx]  <= '0;
            end else if (i_cmd.tick_step) begin
                r_speed[r_idx] <= tick_speed;
                r_idle[r_idx]  <= hit ? '0 : cnt_inc;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_out_channel = r_o_ch;
    assign o_speed_rpm   = r_o_speed;
    assign o_stopped_now = r_o_stopped;
    assign o_last        = r_o_last;

endmodule

[rtl/mctach_ctrl.sv]
// Controller state machine of the tachometer: sequences decode, division, store and tick sweep.
// Depends on mctach_pkg.
module mctach_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  mctach_pkg::t_status i_status,
    output mctach_pkg::t_cmd    o_cmd
);
    import mctach_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.is_tick) begin
                    n_state = S_TICK;
                end else if (i_status.chan_ok) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.cap_write = 1'b1;
                n_state         = S_IDLE;
            end
            S_TICK: begin
                o_cmd.tick_step = 1'b1;
                if (i_status.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[dv/tb.sv]
// Self-checking testbench for multichannel_capture_tachometer_unit: directed script, then random phases.
// Expected speed reports come from a predictor kept inside this file.
// Depends on mctach_pkg and the RTL of the unit; nothing else is needed.
module tb;
    import mctach_pkg::*;

    localparam int unsigned CHANNELS = 16;

    // Request kinds carried on i_req_type.
    typedef enum logic {
        REQ_CAPTURE = 1'b0,
        REQ_TICK    = 1'b1
    } t_req_kind;

    // One speed report, laid out like the result ports.
    typedef struct packed {
        logic [CH_W-1:0]    ch;
        logic [SPEED_W-1:0] speed;
        logic               stopped;
        logic               is_last;
    } t_speed_report;

    // One row of the directed script. A row with is_cfg set rewrites both registers
    // once the unit has gone quiet; any other row is a single transaction. Where
    // has_exp is set, the speed of the only report is given by hand.
    typedef struct {
        logic               is_cfg;
        logic [TICKS_W-1:0] tmo;
        logic [SPEED_W-1:0] numer;
        t_req_kind          kind;
        logic [CH_W-1:0]    ch;
        logic [CAP_W-1:0]   cap;
        logic               has_exp;
        logic [SPEED_W-1:0] exp_speed;
    } t_script_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic               i_req_type;
    logic [CH_W-1:0]    i_channel;
    logic [CAP_W-1:0]   i_capture_value;
    logic               i_cfg_we;
    logic [CFG_IW-1:0]  i_cfg_idx;
    logic [SPEED_W-1:0] i_cfg_data;
    logic               o_valid;
    logic [CH_W-1:0]    o_out_channel;
    logic [SPEED_W-1:0] o_speed_rpm;
    logic               o_stopped_now;
    logic               o_last;

    // Predictor state: a private copy of the capture, speed and idle-tick stores
    // and of both registers.
    logic [CAP_W-1:0]   last_capture [CHANNELS];
    logic [SPEED_W-1:0] held_speed   [CHANNELS];
    logic [TICKS_W-1:0] idle_count   [CHANNELS];
    logic [TICKS_W-1:0] timeout_ticks;
    logic [SPEED_W-1:0] rpm_numerator;

    // Reports that the unit still owes, oldest first.
    t_speed_report pending_reports [$];

    int sent_count;
    int mismatch_count;

    // Directed script. The hand-written speeds follow directly from the period:
    // a first capture of 1 gives a period of 1, a capture equal to the stored one
    // gives the full 0xFFFF, and 0 after 0xFFFF gives the zero period that
    // saturates the speed to the numerator.
    t_script_row directed_script [18] = '{
        // Reset values of the registers: timeout 20, numerator 120000.
        '{1'b0, 8'd0,   24'd0,        REQ_CAPTURE, 4'd0,  16'h0001, 1'b1, 24'd120000},
        '{1'b0, 8'd0,   24'd0,        REQ_CAPTURE, 4'd1,  16'h0000, 1'b1, 24'd1},
        '{1'b0, 8'd0,   24'd0,        REQ_CAPTURE, 4'd2,  16'hFFFF, 1'b1, 24'd1},
        '{1'b0, 8'd0,   24'd0,        REQ_CAPTURE, 4'd2,  16'h0000, 1'b1, 24'd120000},
        '{1'b0, 8'd0,   24'd0,        REQ_CAPTURE, 4'd3,  16'hFFFF, 1'b1, 24'd1},
        '{1'b0, 8'd0,   24'd0,        REQ_CAPTURE, 4'd3,  16'hFFFF, 1'b1, 24'd1},
        '{1'b0, 8'd0,   24'd0,        REQ_CAPTURE, 4'd0,  16'h0079, 1'b1, 24'd1000},
        '{1'b0, 8'd0,   24'd0,        REQ_CAPTURE, 4'd15, 16'h8000, 1'b1, 24'd3},
        '{1'b0, 8'd0,   24'd0,        REQ_TICK,    4'd9,  16'hA5A5, 1'b0, 24'd0},
        // Largest numerator, short timeout: the first tick stops most channels, the second the rest.
        '{1'b1, 8'd2,   24'hFFFFFF,   REQ_CAPTURE, 4'd0,  16'h0000, 1'b0, 24'd0},
        '{1'b0, 8'd0,   24'd0,        REQ_CAPTURE, 4'd4,  16'h0001, 1'b1, 24'hFFFFFF},
        '{1'b0, 8'd0,   24'd0,        REQ_CAPTURE, 4'd5,  16'hFFFF, 1'b1, 24'd256},
        '{1'b0, 8'd0,   24'd0,        REQ_CAPTURE, 4'd5,  16'h0000, 1'b1, 24'hFFFFFF},
        '{1'b0, 8'd0,   24'd0,        REQ_TICK,    4'd0,  16'h0000, 1'b0, 24'd0},
        '{1'b0, 8'd0,   24'd0,        REQ_TICK,    4'd15, 16'hFFFF, 1'b0, 24'd0},
        // Zero numerator and zero timeout: every speed is zero, every tick stops all.
        '{1'b1, 8'd0,   24'd0,        REQ_CAPTURE, 4'd0,  16'h0000, 1'b0, 24'd0},
        '{1'b0, 8'd0,   24'd0,        REQ_CAPTURE, 4'd3,  16'h0000, 1'b1, 24'd0},
        '{1'b0, 8'd0,   24'd0,        REQ_TICK,    4'd6,  16'h5A5A, 1'b0, 24'd0}
    };

    multichannel_capture_tachometer_unit #(
        .CHANNELS(CHANNELS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_req_type     (i_req_type),
        .i_channel      (i_channel),
        .i_capture_value(i_capture_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_out_channel  (o_out_channel),
        .o_speed_rpm    (o_speed_rpm),
        .o_stopped_now  (o_stopped_now),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the unit hangs or stops producing reports.
    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Works out the reports of one accepted transaction and queues them.
    // A capture measures the period since the channel's previous capture; when
    // the new count is not above the stored one the timer has wrapped, and the
    // period is taken as count + 0xFFFF - stored. A tick ages every channel
    // and reports all sixteen in channel order.
    task automatic predict_speeds(input t_req_kind kind, input logic [CH_W-1:0] ch,
                                  input logic [CAP_W-1:0] cap);
        logic [CAP_W:0]     period;
        logic [SPEED_W-1:0] rpm;
        logic [TICKS_W:0]   cnt;
        logic               cleared;
        if (kind == REQ_CAPTURE) begin
            if (cap > last_capture[ch])
                period = {1'b0, cap} - {1'b0, last_capture[ch]};
            else
                period = {1'b0, cap} + PERIOD_WRAP - {1'b0, last_capture[ch]};
            rpm = (period == '0) ? rpm_numerator : rpm_numerator / period;
            last_capture[ch] = cap;
            held_speed[ch]   = rpm;
            idle_count[ch]   = '0;
            pending_reports.push_back(t_speed_report'{ch, rpm, 1'b0, 1'b1});
        end else begin
            for (int i = 0; i < MAX_REPORT; i++) begin
                cnt = {1'b0, idle_count[i]} + 1'b1;
                if (cnt > TICKS_MAX)
                    cnt = {1'b0, TICKS_MAX};
                // A timeout of zero clears every channel on every tick.
                cleared = (cnt >= {1'b0, timeout_ticks});
                if (cleared) begin
                    held_speed[i] = '0;
                    cnt = '0;
                end
                idle_count[i] = cnt[TICKS_W-1:0];
                pending_reports.push_back(t_speed_report'{CH_W'(i), held_speed[i], cleared,
                                                          i == MAX_REPORT - 1});
            end
        end
    endtask

    // Presents one transaction and holds it until the unit takes it. About one
    // transaction in five is preceded by a random gap with i_start low, so that
    // the request rises at every point of the unit's busy time; a window of
    // transactions in the middle of the run is sent back to back with no gaps.
    task automatic issue_transaction(input t_req_kind kind, input logic [CH_W-1:0] ch,
                                     input logic [CAP_W-1:0] cap, input logic has_exp,
                                     input logic [SPEED_W-1:0] exp_speed);
        bit quiet;
        quiet = (sent_count >= 150) && (sent_count < 230);
        if (!quiet && ($urandom_range(0, 99) < 21)) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            i_req_type <= 1'($urandom);
            i_channel <= CH_W'($urandom);
            i_capture_value <= CAP_W'($urandom);
            repeat ($urandom_range(1, 36) - 1) begin
                @(negedge i_clk);
                i_req_type <= 1'($urandom);
                i_channel <= CH_W'($urandom);
                i_capture_value <= CAP_W'($urandom);
            end
        end
        @(negedge i_clk);
        i_start <= 1'b1;
        i_req_type <= kind;
        i_channel <= ch;
        i_capture_value <= cap;
        // The transaction is taken at the first rising edge that sees o_busy low.
        do
            @(posedge i_clk);
        while (o_busy);
        predict_speeds(kind, ch, cap);
        if (has_exp)
            pending_reports[pending_reports.size() - 1].speed = exp_speed;
        sent_count++;
    endtask

    // Drops the request and waits until every owed report has come and the unit
    // is idle, then lets the unit settle before anything else happens.
    task automatic drain_and_settle();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_start <= 1'b0;
        while ((pending_reports.size() != 0 || o_busy) && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (32) @(posedge i_clk);
    endtask

    // Writes both registers on back-to-back cycles. The timeout only uses the low
    // byte of the data bus, so the upper bits carry noise that must be dropped.
    task automatic write_settings(input logic [TICKS_W-1:0] tmo,
                                  input logic [SPEED_W-1:0] numer);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_TIMEOUT;
        i_cfg_data <= {(SPEED_W - TICKS_W)'($urandom), tmo};
        @(negedge i_clk);
        i_cfg_idx <= CFG_NUMER;
        i_cfg_data <= numer;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        timeout_ticks = tmo;
        rpm_numerator = numer;
    endtask

    // One random phase under fixed register values. Captures mostly follow the
    // previous count of their channel by a small or medium step, as a spinning
    // shaft would give; the rest are arbitrary counts, repeats of the stored
    // count, and the 0xFFFF then 0 pair that yields a zero period.
    task automatic run_phase(input logic [TICKS_W-1:0] tmo, input logic [SPEED_W-1:0] numer,
                             input int count, input int tick_pct, input int max_ch);
        logic [CH_W-1:0]  ch;
        logic [CAP_W-1:0] cap;
        int               sel;
        drain_and_settle();
        write_settings(tmo, numer);
        repeat (count) begin
            if ($urandom_range(0, 99) < tick_pct) begin
                issue_transaction(REQ_TICK, CH_W'($urandom), CAP_W'($urandom), 1'b0, '0);
            end else begin
                ch  = CH_W'($urandom_range(0, max_ch));
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    cap = CAP_W'(last_capture[ch] + $urandom_range(1, 300));
                else if (sel < 80)
                    cap = CAP_W'(last_capture[ch] + $urandom_range(301, 20000));
                else if (sel < 88)
                    cap = CAP_W'($urandom);
                else if (sel < 93)
                    cap = last_capture[ch];
                else
                    cap = (last_capture[ch] == 16'hFFFF) ? 16'h0000 : 16'hFFFF;
                issue_transaction(REQ_CAPTURE, ch, cap, 1'b0, '0);
            end
        end
    endtask

    // Every report is checked against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_speed_report want;
        if (i_rst_n && o_valid) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected report: channel %0d speed %0d", o_out_channel, o_speed_rpm);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                if (o_out_channel !== want.ch) begin
                    $error("out_channel: expected %0d, got %0d", want.ch, o_out_channel);
                    mismatch_count++;
                end
                if (o_speed_rpm !== want.speed) begin
                    $error("speed_rpm: expected %0d, got %0d", want.speed, o_speed_rpm);
                    mismatch_count++;
                end
                if (o_stopped_now !== want.stopped) begin
                    $error("stopped_now: expected %0d, got %0d", want.stopped, o_stopped_now);
                    mismatch_count++;
                end
                if (o_last !== want.is_last) begin
                    $error("last: expected %0d, got %0d", want.is_last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req_type = REQ_CAPTURE;
        i_channel = '0;
        i_capture_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_TIMEOUT;
        i_cfg_data = '0;
        sent_count = 0;
        mismatch_count = 0;
        for (int i = 0; i < CHANNELS; i++) begin
            last_capture[i] = '0;
            held_speed[i] = '0;
            idle_count[i] = '0;
        end
        timeout_ticks = TIMEOUT_RESET;
        rpm_numerator = NUMER_RESET;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_script[r]) begin
            if (directed_script[r].is_cfg) begin
                drain_and_settle();
                write_settings(directed_script[r].tmo, directed_script[r].numer);
            end else begin
                issue_transaction(directed_script[r].kind, directed_script[r].ch,
                                  directed_script[r].cap, directed_script[r].has_exp,
                                  directed_script[r].exp_speed);
            end
        end

        // Random phases: reset values, the extremes of both registers, a timeout
        // of zero, and a long tick-heavy phase at the largest timeout so that
        // idle counters climb all the way to 255 before they are cleared.
        run_phase(8'd20, NUMER_RESET, 20, 15, 15);
        run_phase(8'd1, 24'hFFFFFF, 12, 20, 15);
        run_phase(8'd3, SPEED_W'($urandom_range(1, 24'hFFFFFF)), 12, 25, 15);
        run_phase(8'd0, SPEED_W'($urandom_range(0, 1000)), 10, 30, 15);
        run_phase(TICKS_W'($urandom_range(1, 255)), 24'd1, 12, 20, 15);
        run_phase(8'd255, NUMER_RESET, 270, 98, 3);
        run_phase(8'd7, SPEED_W'($urandom_range(1, 24'hFFFFFF)), 12, 25, 15);

        drain_and_settle();
        if (pending_reports.size() != 0) begin
            $error("%0d expected reports never arrived", pending_reports.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
rtl/mctach_pkg.sv
rtl/mctach_div.sv
rtl/mctach_dp.sv
rtl/mctach_ctrl.sv
rtl/multichannel_capture_tachometer_unit.sv
dv/tb.sv
